### rtl/u8u16_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 stream transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

	localparam int CpW     = 21;   // code point width
	localparam int UnitW   = 16;   // UTF-16 code unit width
	localparam int QDepth  = 4;    // output unit queue depth
	localparam int QPtrW   = $clog2(QDepth);
	localparam int QCntW   = $clog2(QDepth + 1);

	localparam logic [CpW-1:0]   REPLACEMENT = 21'h00FFFD;
	localparam logic [CpW-1:0]   SUPP_BASE   = 21'h010000;
	localparam logic [UnitW-1:0] HI_SURR     = 16'hD800;
	localparam logic [UnitW-1:0] LO_SURR     = 16'hDC00;

	// one finished code point handed from decoder to output queue
	typedef struct packed {
		logic           valid;
		logic [CpW-1:0] point;
		logic           fin;
	} dec_point_t;

	// one queued output unit
	typedef struct packed {
		logic [UnitW-1:0] code_unit;
		logic             last_of_run;
		logic             end_of_text;
	} unit_t;

endpackage
`default_nettype wire

### rtl/u8u16_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16 channel interfaces
// Valid/ready channels for input bytes and output UTF-16 units.
// ----------------------------------------------------------------------------
interface u8u16_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       final_byte;

	modport source (output valid, output text_byte, output final_byte, input ready);
	modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface u8u16_unit_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        last_of_run;
	logic        end_of_text;

	modport source (output valid, output code_unit, output last_of_run,
		output end_of_text, input ready);
	modport sink   (input valid, input code_unit, input last_of_run,
		input end_of_text, output ready);
endinterface
`default_nettype wire

### rtl/utf8_to_utf16_stream.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_utf16_stream
// UTF-8 byte stream in, UTF-16 code unit stream out.
// ----------------------------------------------------------------------------
// One UTF-8 byte is taken per request on "text"; each finished code point
// leaves on "units" as one code unit, or as a surrogate pair (high half
// first) when it is 0x10000 or above. Lead bytes pick 0..3 following bytes,
// whose low six bits are appended with no continuation, overlong or range
// check; a stray byte (80..BF, F8..FF) in lead position becomes U+FFFD.
// final_byte closes the string: an unfinished sequence is flushed with the
// bits gathered so far. last_of_run marks the last unit a byte produced and
// end_of_text the final unit of the string. Timing: the decode runs in the
// cycle a byte is accepted and its units are queued at that clock edge, so
// a unit is visible on "units" from the cycle after its byte at the earliest.
// The block accepts one byte every cycle while the four-entry unit queue has
// two free slots; the output side drains one unit per cycle while ready is
// high; with ready held high, four-byte sequences never stall the input.
// Reset (arst_n low) clears the sequence state and empties the queue.
// ----------------------------------------------------------------------------
module utf8_to_utf16_stream
	import u8u16_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	u8u16_byte_if.sink   text,
	u8u16_unit_if.source units
);

	dec_point_t dp;
	logic       room;
	logic       fire;

	assign text.ready = room;
	assign fire       = text.valid && room;

	// byte decode and sequence state
	u8u16_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.text_byte  (text.text_byte),
		.final_byte (text.final_byte),
		.dp         (dp)
	);

	// surrogate split and output queue
	u8u16_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.dp     (dp),
		.room   (room),
		.units  (units)
	);

endmodule
`default_nettype wire

### rtl/u8u16_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_decode
// Sequence state and code point assembly, one byte per accepted request.
// ----------------------------------------------------------------------------
module u8u16_decode
	import u8u16_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire logic [7:0] text_byte,
	input  wire logic       final_byte,
	output dec_point_t      dp
);

	logic [1:0]     pend_q, nxt_pend;
	logic [CpW-1:0] point_q, nxt_point;
	logic [CpW-1:0] acc, lead_pt, cp;
	logic [1:0]     lead_n;
	logic           lead_ok, emit;

	// lead byte classification
	always_comb begin
		lead_ok = 1'b1;
		lead_pt = '0;
		lead_n  = 2'd0;
		if (text_byte[7:5] == 3'b110) begin
			lead_pt = {16'd0, text_byte[4:0]};
			lead_n  = 2'd1;
		end else if (text_byte[7:4] == 4'b1110) begin
			lead_pt = {17'd0, text_byte[3:0]};
			lead_n  = 2'd2;
		end else if (text_byte[7:3] == 5'b11110) begin
			lead_pt = {18'd0, text_byte[2:0]};
			lead_n  = 2'd3;
		end else begin
			lead_ok = 1'b0;
		end
	end

	assign acc = {point_q[CpW-7:0], text_byte[5:0]};

	always_comb begin
		nxt_pend  = pend_q;
		nxt_point = point_q;
		emit      = 1'b0;
		cp        = '0;
		if (pend_q != 2'd0) begin
			// continuation byte, no format check
			if (pend_q == 2'd1 || final_byte) begin
				emit      = 1'b1;
				cp        = acc;
				nxt_pend  = 2'd0;
				nxt_point = '0;
			end else begin
				nxt_pend  = pend_q - 2'd1;
				nxt_point = acc;
			end
		end else if (!text_byte[7]) begin
			emit = 1'b1;
			cp   = {13'd0, text_byte};
		end else if (lead_ok) begin
			if (final_byte) begin
				// string ends on a lead: emit its payload bits alone
				emit = 1'b1;
				cp   = lead_pt;
			end else begin
				nxt_pend  = lead_n;
				nxt_point = lead_pt;
			end
		end else begin
			emit = 1'b1;
			cp   = REPLACEMENT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= 2'd0;
			point_q <= '0;
		end else if (fire) begin
			pend_q  <= nxt_pend;
			point_q <= nxt_point;
		end
	end

	assign dp.valid = fire && emit;
	assign dp.point = cp;
	assign dp.fin   = final_byte;

endmodule
`default_nettype wire

### rtl/u8u16_outq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_outq
// Surrogate split and a small unit queue feeding the output channel.
// ----------------------------------------------------------------------------
module u8u16_outq
	import u8u16_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire dec_point_t dp,
	output logic            room,
	u8u16_unit_if.source    units
);

	unit_t            q_mem [QDepth];
	logic [QPtrW-1:0] wr_q, rd_q;
	logic [QCntW-1:0] count_q;
	logic             pair, pop;
	logic [CpW-1:0]   v;
	unit_t            single_u, hi_u, lo_u;
	logic [QCntW-1:0] n_push;

	assign pair = dp.point >= SUPP_BASE;
	assign v    = dp.point - SUPP_BASE;

	always_comb begin
		single_u.code_unit   = dp.point[UnitW-1:0];
		single_u.last_of_run = 1'b1;
		single_u.end_of_text = dp.fin;
		hi_u.code_unit       = HI_SURR | UnitW'(v[CpW-1:10]);
		hi_u.last_of_run     = 1'b0;
		hi_u.end_of_text     = 1'b0;
		lo_u.code_unit       = LO_SURR | {6'd0, v[9:0]};
		lo_u.last_of_run     = 1'b1;
		lo_u.end_of_text     = dp.fin;
	end

	assign n_push = !dp.valid ? QCntW'(0) : (pair ? QCntW'(2) : QCntW'(1));
	assign pop    = (count_q != '0) && units.ready;
	// room for a worst-case pair
	assign room   = count_q <= QCntW'(QDepth - 2);

	always_ff @(posedge clk) begin
		if (dp.valid) begin
			q_mem[wr_q] <= pair ? hi_u : single_u;
			if (pair) begin
				q_mem[wr_q + QPtrW'(1)] <= lo_u;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + n_push[QPtrW-1:0];
			rd_q    <= rd_q + QPtrW'(pop);
			count_q <= count_q + n_push - QCntW'(pop);
		end
	end

	assign units.valid       = count_q != '0;
	assign units.code_unit   = q_mem[rd_q].code_unit;
	assign units.last_of_run = q_mem[rd_q].last_of_run;
	assign units.end_of_text = q_mem[rd_q].end_of_text;

endmodule
`default_nettype wire

### rtl/u8u16_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_checker
// Port-level checks for the transcoder, bound to the top level.
// ----------------------------------------------------------------------------
module u8u16_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] code_unit,
	input wire logic        last_of_run,
	input wire logic        end_of_text
);

	// stalled unit holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(code_unit))
		else $error("output unit changed while stalled");

	// string end only on the last unit of a run
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_text |-> last_of_run)
		else $error("end_of_text without last_of_run");

	// a non-last unit always lies in the surrogate range D800..DFFF
	a_hi: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |-> code_unit[15:11] == 5'b11011)
		else $error("non-last unit is not a surrogate");

	// the low half is already queued when the high half leaves
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid && last_of_run)
		else $error("surrogate pair split");

endmodule

bind utf8_to_utf16_stream u8u16_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (units.valid),
	.out_ready   (units.ready),
	.code_unit   (units.code_unit),
	.last_of_run (units.last_of_run),
	.end_of_text (units.end_of_text)
);
`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - testbench for utf8_to_utf16_stream
// Sends UTF-8 strings byte by byte on the text channel: directed cases, then
// mostly well-formed random strings with some stray bytes and cut-off
// sequences. A predictor in the driver turns every accepted byte into the
// UTF-16 units it should produce, and the monitor checks the units in order.
// ----------------------------------------------------------------------------
module tb;
	import u8u16_pkg::*;

	// run shape
	localparam int IDLE_PCT     = 14;      // idle chance per slot, percent
	localparam int CALM_LO      = 500;     // no idling on either side in this
	localparam int CALM_HI      = 800;     //   window of accepted requests
	localparam int HOLD_AT      = 300;     // long output hold starts here
	localparam int HOLD_LEN     = 200;     // and lasts this many cycles
	localparam int DRAIN_EVERY  = 300;     // sender pause spacing, in requests
	localparam int RANDOM_BYTES = 1200;
	localparam int LIMIT_CYCLES = 200000;
	localparam int MAX_PRINTS   = 30;

	// UTF-8 lead classes
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_TAG  = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_TAG  = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_TAG  = 8'hF0;
	localparam logic [7:0] CONT_TAG   = 8'h80;

	// UTF-16 side
	localparam logic [20:0] REPL_POINT = 21'h00FFFD;
	localparam logic [20:0] SUPP_FLOOR = 21'h010000;
	localparam logic [15:0] HI_BASE    = 16'hD800;
	localparam logic [15:0] LO_BASE    = 16'hDC00;

	// one planned request on the text channel
	typedef struct packed {
		logic [7:0] text_byte;
		logic       final_byte;
		logic       drain;      // hold this one back until all units are in
	} byte_req_t;

	logic clk;
	logic arst_n;

	u8u16_byte_if text_if();
	u8u16_unit_if units_if();

	utf8_to_utf16_stream dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_if),
		.units  (units_if)
	);

	byte_req_t byte_plan[$];   // requests not yet offered
	unit_t     units_due[$];   // units predicted, not yet seen

	// predictor state
	logic [1:0]  seq_left;     // following bytes still owed
	logic [20:0] seq_point;    // code point gathered so far

	int bytes_sent;
	int units_seen;
	int n_strings;
	int n_pairs;
	int n_repl;
	int n_err;
	int cycle_cnt;
	int hold_left;
	bit hold_done;
	bit drain_next;

	// both sides run flat out inside this window
	wire calm = (bytes_sent >= CALM_LO) && (bytes_sent < CALM_HI);

	// ------------------------------------------------------------------
	// clock and reset
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		text_if.valid = 1'b0;
		text_if.text_byte = '0;
		text_if.final_byte = 1'b0;
		units_if.ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		if (n_err < MAX_PRINTS)
			$display("%0t ns  mismatch: %s", $realtime, msg);
		n_err++;
	endtask

	// one finished code point -> one unit, or a surrogate pair (high first).
	// Points past 0x10FFFF still take the pair path; the high half may then
	// run above 0xDBFF.
	task automatic split_point(input logic [20:0] cp, input logic fin);
		logic [20:0] v;
		if (cp >= SUPP_FLOOR) begin
			v = cp - SUPP_FLOOR;
			units_due.push_back('{code_unit: HI_BASE | {5'd0, v[20:10]},
				last_of_run: 1'b0, end_of_text: 1'b0});
			units_due.push_back('{code_unit: LO_BASE | {6'd0, v[9:0]},
				last_of_run: 1'b1, end_of_text: fin});
			n_pairs++;
		end else begin
			units_due.push_back('{code_unit: cp[15:0], last_of_run: 1'b1,
				end_of_text: fin});
		end
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic fin);
		bit lead;
		lead = 1'b0;
		if (seq_left != 2'd0) begin
			// any byte is taken as a follower, 10xxxxxx or not
			seq_point = {seq_point[14:0], b[5:0]};
			seq_left = seq_left - 2'd1;
			if (seq_left == 2'd0 || fin) begin
				// complete, or cut short by the end of the string
				split_point(seq_point, fin);
				seq_left = 2'd0;
				seq_point = '0;
			end
		end else if (!b[7]) begin
			split_point({13'd0, b}, fin);
		end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
			seq_point = {16'd0, b[4:0]};
			seq_left = 2'd1;
			lead = 1'b1;
		end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
			seq_point = {17'd0, b[3:0]};
			seq_left = 2'd2;
			lead = 1'b1;
		end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
			seq_point = {18'd0, b[2:0]};
			seq_left = 2'd3;
			lead = 1'b1;
		end else begin
			// stray follower or F8..FF in lead position
			split_point(REPL_POINT, fin);
			n_repl++;
		end
		// a lead that ends the string goes out with its own payload bits
		if (lead && fin) begin
			split_point(seq_point, fin);
			seq_left = 2'd0;
			seq_point = '0;
		end
	endtask

	// ------------------------------------------------------------------
	// stimulus building
	// ------------------------------------------------------------------
	task automatic queue_byte(input logic [7:0] b, input logic fin);
		byte_plan.push_back('{text_byte: b, final_byte: fin, drain: drain_next});
		drain_next = 1'b0;
	endtask

	// follower byte; now and then not of the 10xxxxxx form
	function automatic logic [7:0] follower(input logic [5:0] bits);
		logic [1:0] top;
		top = 2'b10;
		if ($urandom_range(0, 9) == 0)
			top = 2'($urandom());
		return {top, bits};
	endfunction

	// one random character; mostly well formed, some noise and cut-offs
	task automatic queue_char(input bit last_char);
		int pick;
		int keep;
		logic [20:0] cp;
		logic [7:0] seq[$];
		pick = $urandom_range(0, 99);
		cp = 21'($urandom());
		if (pick < 40) begin
			seq.push_back({1'b0, cp[6:0]});
		end else if (pick < 60) begin
			seq.push_back(LEAD2_TAG | {3'd0, cp[10:6]});
			seq.push_back(follower(cp[5:0]));
		end else if (pick < 75) begin
			seq.push_back(LEAD3_TAG | {4'd0, cp[15:12]});
			seq.push_back(follower(cp[11:6]));
			seq.push_back(follower(cp[5:0]));
		end else if (pick < 90) begin
			// full 21-bit range, so points above 0x10FFFF show up too
			seq.push_back(LEAD4_TAG | {5'd0, cp[20:18]});
			seq.push_back(follower(cp[17:12]));
			seq.push_back(follower(cp[11:6]));
			seq.push_back(follower(cp[5:0]));
		end else if (pick < 95) begin
			case ($urandom_range(0, 2))
				0: seq.push_back(8'($urandom_range(8'h80, 8'hBF)));
				1: seq.push_back(8'($urandom_range(8'hF8, 8'hFF)));
				default: seq.push_back(8'($urandom_range(0, 255)));
			endcase
		end else begin
			// broken sequence: lead plus too few followers
			seq.push_back(LEAD4_TAG | {5'd0, cp[20:18]});
			seq.push_back(CONT_TAG | {2'd0, cp[17:12]});
			seq.push_back(CONT_TAG | {2'd0, cp[11:6]});
			keep = $urandom_range(1, 3);
			while (seq.size() > keep)
				void'(seq.pop_back());
		end
		foreach (seq[i])
			queue_byte(seq[i], last_char && (i == seq.size() - 1));
	endtask

	// ------------------------------------------------------------------
	// driver: offers planned requests, predicts on every accepted one
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_if.valid <= 1'b0;
			text_if.text_byte <= '0;
			text_if.final_byte <= 1'b0;
		end else begin
			if (text_if.valid && text_if.ready) begin
				decode_byte(text_if.text_byte, text_if.final_byte);
				bytes_sent++;
				if (text_if.final_byte)
					n_strings++;
			end
			// a held request stays put; otherwise pick the next one or idle
			if (!text_if.valid || text_if.ready) begin
				if (byte_plan.size() != 0
						&& !(byte_plan[0].drain && units_due.size() != 0)
						&& (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					text_if.valid <= 1'b1;
					text_if.text_byte <= byte_plan[0].text_byte;
					text_if.final_byte <= byte_plan[0].final_byte;
					void'(byte_plan.pop_front());
				end else begin
					text_if.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: checks each unit against the oldest prediction and owns
	// the ready side, including the one long hold
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		unit_t want;
		if (!arst_n) begin
			units_if.ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (units_if.valid && units_if.ready) begin
				units_seen++;
				if (units_due.size() == 0) begin
					report_mismatch($sformatf("unit %04h with nothing expected",
						units_if.code_unit));
				end else begin
					want = units_due.pop_front();
					if (units_if.code_unit !== want.code_unit)
						report_mismatch($sformatf("unit %0d code_unit %04h, want %04h",
							units_seen, units_if.code_unit, want.code_unit));
					if (units_if.last_of_run !== want.last_of_run)
						report_mismatch($sformatf("unit %0d last_of_run %b, want %b",
							units_seen, units_if.last_of_run, want.last_of_run));
					if (units_if.end_of_text !== want.end_of_text)
						report_mismatch($sformatf("unit %0d end_of_text %b, want %b",
							units_seen, units_if.end_of_text, want.end_of_text));
				end
			end
			// long hold: the sender keeps going so the unit queue fills
			if (!hold_done && bytes_sent >= HOLD_AT) begin
				hold_left = HOLD_LEN;
				hold_done = 1'b1;
			end
			if (hold_left != 0) begin
				hold_left--;
				units_if.ready <= 1'b0;
			end else begin
				units_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// ------------------------------------------------------------------
	// watchdog
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d units outstanding",
				cycle_cnt, units_due.size());
			$display("** utf8_to_utf16_stream: FAILED **");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus plan and end of run
	// ------------------------------------------------------------------
	initial begin
		int n_chars;
		int next_drain;

		seq_left = 2'd0;
		seq_point = '0;
		drain_next = 1'b0;

		// ASCII extremes
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h7F, 1'b1);
		// two, three and four byte forms
		queue_byte(8'hC2, 1'b0);
		queue_byte(8'hA9, 1'b0);
		queue_byte(8'hE2, 1'b0);
		queue_byte(8'h82, 1'b0);
		queue_byte(8'hAC, 1'b0);
		queue_byte(8'hF0, 1'b0);
		queue_byte(8'h9F, 1'b0);
		queue_byte(8'h98, 1'b0);
		queue_byte(8'h80, 1'b1);
		// stray bytes in lead position, both ranges, both ends
		queue_byte(8'h80, 1'b0);
		queue_byte(8'hBF, 1'b0);
		queue_byte(8'hF8, 1'b0);
		queue_byte(8'hFF, 1'b1);
		// follower that is not 10xxxxxx
		queue_byte(8'hC3, 1'b0);
		queue_byte(8'h41, 1'b1);
		// largest point: pair with the high half past DBFF
		queue_byte(8'hF7, 1'b0);
		queue_byte(8'hBF, 1'b0);
		queue_byte(8'hBF, 1'b0);
		queue_byte(8'hBF, 1'b1);
		// string ends mid-sequence
		queue_byte(8'hE2, 1'b0);
		queue_byte(8'h82, 1'b1);
		// string ends on a lead byte
		queue_byte(8'hF4, 1'b1);

		// random strings; every so often the sender waits for a full drain
		next_drain = byte_plan.size();
		while (byte_plan.size() < RANDOM_BYTES + 24) begin
			if (byte_plan.size() >= next_drain) begin
				drain_next = 1'b1;
				next_drain += DRAIN_EVERY;
			end
			n_chars = $urandom_range(1, 10);
			for (int i = 0; i < n_chars; i++)
				queue_char(i == n_chars - 1);
		end

		wait (arst_n);
		wait (byte_plan.size() == 0 && !text_if.valid);
		wait (units_due.size() == 0);
		// keep the clock running to catch any unit the block should not send
		repeat (20) @(posedge clk);

		foreach (units_due[i])
			report_mismatch($sformatf("unit %04h never arrived", units_due[i].code_unit));

		$display("covered: %0d bytes in %0d strings, %0d units (%0d pairs, %0d U+FFFD)",
			bytes_sent, n_strings, units_seen, n_pairs, n_repl);
		$display("flow: random idles both sides, %0d-cycle output hold, drain pauses",
			HOLD_LEN);
		if (n_err == 0) begin
			$display("** utf8_to_utf16_stream: PASSED **");
		end else begin
			$display("%0d mismatches", n_err);
			$display("** utf8_to_utf16_stream: FAILED **");
		end
		$finish;
	end

endmodule

### utf8_to_utf16_stream.f
rtl/u8u16_pkg.sv
rtl/u8u16_if.sv
rtl/u8u16_decode.sv
rtl/u8u16_outq.sv
rtl/utf8_to_utf16_stream.sv
rtl/u8u16_checker.sv
dv/tb.sv
